@@ src/scbs_pkg.sv @@
// shared types and constants of the sequence slot batch scheduler
package scbs_pkg;

  localparam int RUNNERS     = 4;
  localparam int SLOTS       = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int MAP_ENTRIES = 64;
  localparam int MAX_RESULTS = 8;

  localparam int NSLOT = RUNNERS * SLOTS;
  localparam int RW    = (RUNNERS > 1) ? $clog2(RUNNERS) : 1;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int MW    = $clog2(MAP_ENTRIES);
  localparam int MCW   = $clog2(MAP_ENTRIES + 1);
  localparam int HSW   = $clog2(SLOTS + 1);
  localparam int NW    = $clog2(MAX_RESULTS + 1);
  localparam int FAW   = $clog2(NSLOT * QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_BACKLOG    = 3'd1,
    ST_NO_ID      = 3'd2,
    ST_MAP_FULL   = 3'd3,
    ST_QUEUE_FULL = 3'd4,
    ST_BATCH_ITEM = 3'd5,
    ST_NO_WORK    = 3'd6
  } status_t;

  typedef enum logic [0:0] {
    REQ_ENQUEUE = 1'b0,
    REQ_ROUND   = 1'b1
  } req_t;

  typedef enum logic [0:0] {
    REG_ACTIVE_RUNNERS = 1'b0,
    REG_ACTIVE_SLOTS   = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_CMP,
    S_APPLY,
    S_EMIT,
    S_RND_CHK,
    S_RND_DATA
  } state_t;

  typedef struct packed {
    logic [2:0] active_runners;
    logic [3:0] active_slots;
  } cfg_t;

  typedef struct packed {
    logic [63:0]   key;
    logic          backlog;
    logic [RW-1:0] runner;
    logic [SW-1:0] slot;
  } map_entry_t;

  typedef struct packed {
    status_t     status;
    logic [1:0]  runner;
    logic [2:0]  slot;
    logic [15:0] tag;
    logic        last;
  } result_t;

endpackage

@@ src/scbs_ram.sv @@
// single-port-write, single-port-read ram with registered read data
module scbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/scbs_apb_regs.sv @@
// apb configuration registers
module scbs_apb_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output scbs_pkg::cfg_t      cfg
);
  import scbs_pkg::*;

  logic     wr;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_runners <= 3'd4;
      cfg.active_slots   <= 4'd8;
    end else if (wr) begin
      case (sel)
        REG_ACTIVE_RUNNERS: cfg.active_runners <= pwdata[2:0];
        REG_ACTIVE_SLOTS:   cfg.active_slots   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_ACTIVE_RUNNERS: prdata = {29'd0, cfg.active_runners};
      REG_ACTIVE_SLOTS:   prdata = {28'd0, cfg.active_slots};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

@@ src/sequence_slot_batch_scheduler_unit.sv @@
// sequence slot batch scheduler top level
// An enqueue request searches the id map one stored entry at a time, reading
// each entry in S_LOOK and comparing its key in S_CMP, over the N ids bound so
// far (up to MAP_ENTRIES); an id of zero answers without a map search. A round
// request visits the slots of the selected runner up to its highest used slot,
// one slot per cycle while they hold no queued tag, and for each popped tag it
// waits in S_RND_DATA on the queue memory read and on a stalled output. The map
// key search goes through the single read port of the map memory. No clearing pass is needed after reset.
module sequence_slot_batch_scheduler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [63:0] seq_id,
  input  logic [15:0] request_tag,
  input  logic [1:0]  runner_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [1:0]  runner,
  output logic [2:0]  slot,
  output logic [15:0] tag_out,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scbs_pkg::*;

  cfg_t cfg;

  scbs_apb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t state, state_next;

  // latched request
  req_t        req_q;
  logic [63:0] id_q;
  logic [15:0] tag_q;
  logic [1:0]  rsel_q;

  // map
  logic [MCW-1:0] map_cnt;
  logic [MCW-1:0] idx;
  logic           map_we, map_re;
  map_entry_t     map_wdata, map_rdata;

  // binding of the current request
  logic          b_backlog;
  logic [RW-1:0] b_r;
  logic [SW-1:0] b_s;

  // slot state
  logic [NSLOT-1:0] bound;
  logic [HW-1:0]    head  [NSLOT];
  logic [CW-1:0]    count [NSLOT];
  logic [HSW-1:0]   highest [RUNNERS];

  // fifo memory
  logic           fifo_we, fifo_re;
  logic [FAW-1:0] fifo_waddr, fifo_raddr;
  logic [15:0]    fifo_rdata;

  // round
  logic [HSW-1:0] rs;
  logic [NW-1:0]  rn;
  logic           pend_valid;
  result_t        pend;
  result_t        res;

  // output register
  logic    out_free;
  logic    out_load;
  result_t out_data, out_q;

  scbs_ram #(.WIDTH($bits(map_entry_t)), .DEPTH(MAP_ENTRIES)) u_map (
    .clk,
    .we(map_we), .waddr(map_cnt[MW-1:0]), .wdata(map_wdata),
    .re(map_re), .raddr(idx[MW-1:0]), .rdata(map_rdata)
  );

  scbs_ram #(.WIDTH(16), .DEPTH(NSLOT * QUEUE_DEPTH)) u_fifo (
    .clk,
    .we(fifo_we), .waddr(fifo_waddr), .wdata(tag_q),
    .re(fifo_re), .raddr(fifo_raddr), .rdata(fifo_rdata)
  );

  // free slot search
  logic          found;
  logic [RW-1:0] fr;
  logic [SW-1:0] fs;

  always_comb begin
    found = 1'b0;
    fr    = '0;
    fs    = '0;
    for (int r = RUNNERS - 1; r >= 0; r--) begin
      for (int s = SLOTS - 1; s >= 0; s--) begin
        if (r < int'(cfg.active_runners) && s < int'(cfg.active_slots) &&
            !bound[r * SLOTS + s]) begin
          found = 1'b1;
          fr    = RW'(r);
          fs    = SW'(s);
        end
      end
    end
  end

  // derived conditions
  logic           look_end, map_full, key_hit, enq_full, rnd_done, rnd_work;
  logic           rsel_ok;
  logic [RW-1:0]  rr;
  logic [QW-1:0]  eq, rq;
  logic [CW:0]    psum;
  logic [HW-1:0]  pos;

  assign rsel_ok  = int'(rsel_q) < RUNNERS;
  assign rr       = RW'(rsel_q);
  assign eq       = QW'(int'(b_r) * SLOTS + int'(b_s));
  assign rq       = QW'(int'(rr) * SLOTS + int'(rs));
  assign look_end = idx == map_cnt;
  assign map_full = map_cnt == MCW'(MAP_ENTRIES);
  assign key_hit  = map_rdata.key == id_q;
  assign enq_full = count[eq] == CW'(QUEUE_DEPTH);
  assign psum     = (CW+1)'(head[eq]) + (CW+1)'(count[eq]);
  assign pos      = HW'((psum >= (CW+1)'(QUEUE_DEPTH)) ? psum - (CW+1)'(QUEUE_DEPTH) : psum);
  assign rnd_done = !rsel_ok || rs >= highest[rr] || rs >= HSW'(SLOTS) ||
                    rn == NW'(MAX_RESULTS);
  assign rnd_work = bound[rq] && count[rq] != '0;
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (req_t'(req_type) == REQ_ROUND) state_next = S_RND_CHK;
          else if (seq_id == 64'd0)          state_next = S_EMIT;
          else                               state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!look_end)     state_next = S_CMP;
        else if (map_full) state_next = S_EMIT;
        else               state_next = S_APPLY;
      end
      S_CMP:      state_next = key_hit ? S_APPLY : S_LOOK;
      S_APPLY:    state_next = S_EMIT;
      S_EMIT:     state_next = out_free ? S_IDLE : S_EMIT;
      S_RND_CHK: begin
        if (rnd_done)      state_next = S_EMIT;
        else if (rnd_work) state_next = S_RND_DATA;
      end
      S_RND_DATA: begin
        if (!pend_valid || out_free) state_next = S_RND_CHK;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    in_stall   = state != S_IDLE;
    map_re     = state == S_LOOK && !look_end;
    map_we     = state == S_LOOK && look_end && !map_full;
    map_wdata  = '{key: id_q, backlog: !found, runner: found ? fr : '0,
                   slot: found ? fs : '0};
    fifo_we    = state == S_APPLY && !b_backlog && !enq_full;
    fifo_waddr = FAW'(int'(eq) * QUEUE_DEPTH + int'(pos));
    fifo_re    = state == S_RND_CHK && !rnd_done && rnd_work;
    fifo_raddr = FAW'(int'(rq) * QUEUE_DEPTH + int'(head[rq]));
    out_load   = 1'b0;
    out_data   = res;
    case (state)
      S_EMIT: out_load = out_free;
      S_RND_DATA: begin
        out_load = pend_valid && out_free;
        out_data = pend;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      map_cnt    <= '0;
      bound      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
      for (int i = 0; i < RUNNERS; i++) begin
        highest[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load)      out_valid <= 1'b1;
      else if (out_free) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pend_valid <= 1'b0;
            idx        <= '0;
            rs         <= '0;
            rn         <= '0;
            res        <= '{status: ST_NO_ID, runner: 2'd0, slot: 3'd0, tag: 16'd0,
                            last: 1'b1};
          end
        end
        S_LOOK: begin
          if (look_end) begin
            if (map_full) begin
              res.status <= ST_MAP_FULL;
            end else begin
              map_cnt   <= map_cnt + 1'b1;
              b_backlog <= map_wdata.backlog;
              b_r       <= map_wdata.runner;
              b_s       <= map_wdata.slot;
            end
          end
        end
        S_CMP: begin
          idx <= idx + 1'b1;
          if (key_hit) begin
            b_backlog <= map_rdata.backlog;
            b_r       <= map_rdata.runner;
            b_s       <= map_rdata.slot;
          end
        end
        S_APPLY: begin
          if (b_backlog) begin
            res.status <= ST_BACKLOG;
          end else begin
            res.runner <= 2'(b_r);
            res.slot   <= 3'(b_s);
            if (enq_full) begin
              res.status <= ST_QUEUE_FULL;
            end else begin
              res.status <= ST_QUEUED;
              count[eq]  <= count[eq] + 1'b1;
              bound[eq]  <= 1'b1;
              if (highest[b_r] < HSW'(b_s) + 1'b1) highest[b_r] <= HSW'(b_s) + 1'b1;
            end
          end
        end
        S_RND_CHK: begin
          if (rnd_done) begin
            pend_valid <= 1'b0;
            if (pend_valid) begin
              res <= '{status: pend.status, runner: pend.runner, slot: pend.slot,
                       tag: pend.tag, last: 1'b1};
            end else begin
              res <= '{status: ST_NO_WORK, runner: rsel_q, slot: 3'd0, tag: 16'd0,
                       last: 1'b1};
            end
          end else begin
            if (rnd_work) begin
              head[rq]  <= HW'((int'(head[rq]) + 1) % QUEUE_DEPTH);
              count[rq] <= count[rq] - 1'b1;
            end else begin
              rs <= rs + 1'b1;
            end
          end
        end
        S_RND_DATA: begin
          if (!pend_valid || out_free) begin
            pend_valid <= 1'b1;
            pend       <= '{status: ST_BATCH_ITEM, runner: rsel_q, slot: 3'(rs),
                            tag: fifo_rdata, last: 1'b0};
            rn         <= rn + 1'b1;
            rs         <= rs + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req_q  <= req_t'(req_type);
      id_q   <= seq_id;
      tag_q  <= request_tag;
      rsel_q <= runner_select;
    end
    if (out_load) out_q <= out_data;
  end

  assign status  = out_q.status;
  assign runner  = out_q.runner;
  assign slot    = out_q.slot;
  assign tag_out = out_q.tag;
  assign last    = out_q.last;

`ifndef SYNTHESIS
  a_map_cnt: assert property (@(posedge clk) disable iff (rst)
    map_cnt <= MCW'(MAP_ENTRIES))
    else $error("map fill count overflow");

  a_pend_in_round: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_RND_CHK || state == S_RND_DATA))
    else $error("pending batch item outside a round");

  a_enq_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK || state == S_CMP || state == S_APPLY) |-> req_q == REQ_ENQUEUE)
    else $error("round request in map lookup");
`endif

endmodule
